// ===== src/rbd_pkg.sv =====
// Shared constants and action codes for the ring buffer deque.
package rbd_pkg;
    localparam int DEPTH_DEF      = 64;
    localparam int DATA_WIDTH_DEF = 32;

    localparam logic [2:0] ACT_PUSH_FRONT = 3'd0;
    localparam logic [2:0] ACT_PUSH_BACK  = 3'd1;
    localparam logic [2:0] ACT_POP_FRONT  = 3'd2;
    localparam logic [2:0] ACT_POP_BACK   = 3'd3;
    localparam logic [2:0] ACT_CONTAINS   = 3'd4;
    localparam logic [2:0] ACT_SORT       = 3'd5;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
endpackage

// ===== src/ring_buffer_deque_core.sv =====
// Top level of the ring buffer deque: request decode, sequencer and element store.
//
// Usage
//   Input channel: i_valid / o_stall with i_action and i_elem_value. A word is
//   taken at a clock edge where i_valid is high and o_stall is low.
//   Output channel: o_valid / i_stall with o_status, o_data_out, o_found, o_count.
//   Config: i_cfg_we / i_cfg_data write compare_signed (1 = signed order for sort).
//   Write it only while the block is idle.
// Sequence (from the accepting edge to o_valid)
//   Push, any rejected request, contains or sort with nothing to walk, unused
//   code: straight to S_OUT. Pop: a synchronous read of the store in S_POP, then S_OUT.
//   Contains: a read and a compare per element, stopping at the first match.
//   Sort (count >= 2): per pass, read element i, then read and compare each later
//   element, then write the minimum to slot i and old element i to its slot.
//   One request is worked on at a time; o_stall is high while busy or while a
//   result waits, so the next word is taken at the edge after the result goes.
// Reset
//   Synchronous active-low reset empties the deque and clears compare_signed.
//   The store itself is not cleared; only data from occupied slots is ever used.
// Stall
//   While i_stall is high hold the result in the output register; take no word.
module ring_buffer_deque_core #(
    parameter int DEPTH      = rbd_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = rbd_pkg::DATA_WIDTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_data,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [2:0]                  i_action,
    input  logic [31:0]                 i_elem_value,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [1:0]                  o_status,
    output logic [31:0]                 o_data_out,
    output logic                        o_found,
    output logic [$clog2(DEPTH+1)-1:0]  o_count
);
    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_POP   = 4'd1;
    localparam logic [3:0] S_CRD   = 4'd2;  // contains: issue read
    localparam logic [3:0] S_CCMP  = 4'd3;  // contains: compare
    localparam logic [3:0] S_IRD   = 4'd4;  // sort: read element i
    localparam logic [3:0] S_ILAT  = 4'd5;  // sort: capture element i
    localparam logic [3:0] S_JRD   = 4'd6;  // sort: read element j
    localparam logic [3:0] S_JCMP  = 4'd7;  // sort: compare element j
    localparam logic [3:0] S_SWAP  = 4'd8;  // sort: write min to slot i
    localparam logic [3:0] S_SWAP2 = 4'd9;  // sort: write old i to slot m
    localparam logic [3:0] S_OUT   = 4'd10;

    logic [DATA_WIDTH-1:0] mem [DEPTH];
    logic [DATA_WIDTH-1:0] r_rdata;

    logic [3:0]            r_state, n_state;
    logic [AW-1:0]         r_head, n_head, r_tail, n_tail;
    logic [CW-1:0]         r_cnt, n_cnt;
    logic                  r_sgn;
    logic [DATA_WIDTH-1:0] r_key, n_key;      // search value / element i
    logic [DATA_WIDTH-1:0] r_min, n_min;
    logic [CW-1:0]         r_i, n_i, r_j, n_j, r_m, n_m;
    logic                  r_ovalid, n_ovalid;
    logic [1:0]            r_status, n_status;
    logic [DATA_WIDTH-1:0] r_data, n_data;
    logic                  r_found, n_found;

    logic                  we;
    logic [AW-1:0]         waddr, raddr;
    logic [DATA_WIDTH-1:0] wdata;
    logic                  accept;
    logic                  lt;
    logic [DATA_WIDTH-1:0] sign_bit;

    assign sign_bit = DATA_WIDTH'(r_sgn) << (DATA_WIDTH - 1);
    assign lt       = (r_rdata ^ sign_bit) < (r_min ^ sign_bit);
    assign accept   = i_valid && !o_stall;
    assign o_stall  = (r_state != S_IDLE) || r_ovalid;

    // h < DEPTH and n <= DEPTH, so one conditional subtract wraps the sum
    function automatic logic [AW-1:0] slot(input logic [AW-1:0] h, input logic [CW-1:0] n);
        logic [CW:0] s;
        s = (CW+1)'(h) + (CW+1)'(n);
        if (s >= (CW+1)'(DEPTH)) s = s - (CW+1)'(DEPTH);
        return AW'(s);
    endfunction

    always_comb begin
        n_state  = r_state;
        n_head   = r_head;
        n_tail   = r_tail;
        n_cnt    = r_cnt;
        n_key    = r_key;
        n_min    = r_min;
        n_i      = r_i;
        n_j      = r_j;
        n_m      = r_m;
        n_ovalid = r_ovalid && i_stall;
        n_status = r_status;
        n_data   = r_data;
        n_found  = r_found;
        we       = 1'b0;
        waddr    = r_head;
        wdata    = DATA_WIDTH'(i_elem_value);
        raddr    = r_head;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_status = rbd_pkg::ST_OK;
                    n_data   = '0;
                    n_found  = 1'b0;
                    n_key    = DATA_WIDTH'(i_elem_value);
                    n_state  = S_OUT;
                    case (i_action)
                        rbd_pkg::ACT_PUSH_FRONT, rbd_pkg::ACT_PUSH_BACK: begin
                            if (r_cnt == FULL_CNT) begin
                                n_status = rbd_pkg::ST_FULL;
                            end else begin
                                we    = 1'b1;
                                n_cnt = r_cnt + 1'b1;
                                if (i_action == rbd_pkg::ACT_PUSH_FRONT) begin
                                    n_head = slot(r_head, FULL_CNT - 1'b1);
                                    waddr  = n_head;
                                end else begin
                                    waddr  = r_tail;
                                    n_tail = slot(r_tail, CW'(1));
                                end
                            end
                        end
                        rbd_pkg::ACT_POP_FRONT, rbd_pkg::ACT_POP_BACK: begin
                            if (r_cnt == '0) begin
                                n_status = rbd_pkg::ST_EMPTY;
                            end else begin
                                n_cnt   = r_cnt - 1'b1;
                                n_state = S_POP;
                                if (i_action == rbd_pkg::ACT_POP_FRONT) begin
                                    raddr  = r_head;
                                    n_head = slot(r_head, CW'(1));
                                end else begin
                                    n_tail = slot(r_tail, FULL_CNT - 1'b1);
                                    raddr  = n_tail;
                                end
                            end
                        end
                        rbd_pkg::ACT_CONTAINS: begin
                            n_i = '0;
                            if (r_cnt != '0) n_state = S_CRD;
                        end
                        rbd_pkg::ACT_SORT: begin
                            n_i = '0;
                            if (r_cnt > CW'(1)) n_state = S_IRD;
                        end
                        default: ;
                    endcase
                end
            end
            S_POP: begin
                n_data  = r_rdata;
                n_state = S_OUT;
            end
            S_CRD: begin
                raddr   = slot(r_head, r_i);
                n_state = S_CCMP;
            end
            S_CCMP: begin
                if (r_rdata == r_key) begin
                    n_found = 1'b1;
                    n_state = S_OUT;
                end else if (r_i + 1'b1 == r_cnt) begin
                    n_state = S_OUT;
                end else begin
                    n_i     = r_i + 1'b1;
                    n_state = S_CRD;
                end
            end
            S_IRD: begin
                raddr   = slot(r_head, r_i);
                n_state = S_ILAT;
            end
            S_ILAT: begin
                n_key   = r_rdata;
                n_min   = r_rdata;
                n_m     = r_i;
                n_j     = r_i + 1'b1;
                n_state = S_JRD;
            end
            S_JRD: begin
                raddr   = slot(r_head, r_j);
                n_state = S_JCMP;
            end
            S_JCMP: begin
                if (lt) begin
                    n_min = r_rdata;
                    n_m   = r_j;
                end
                if (r_j + 1'b1 == r_cnt) begin
                    n_state = S_SWAP;
                end else begin
                    n_j     = r_j + 1'b1;
                    n_state = S_JRD;
                end
            end
            S_SWAP: begin
                we      = 1'b1;
                waddr   = slot(r_head, r_i);
                wdata   = r_min;
                n_state = S_SWAP2;
            end
            S_SWAP2: begin
                // write old element i into the min slot (no-op when m == i)
                we    = 1'b1;
                waddr = slot(r_head, r_m);
                wdata = (r_m == r_i) ? r_min : r_key;
                if (r_i + CW'(2) >= r_cnt) begin
                    n_state = S_OUT;
                end else begin
                    n_i     = r_i + 1'b1;
                    n_state = S_IRD;
                end
            end
            S_OUT: begin
                n_ovalid = 1'b1;
                n_state  = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we) mem[waddr] <= wdata;
        r_rdata <= mem[raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_head   <= '0;
            r_tail   <= '0;
            r_cnt    <= '0;
            r_sgn    <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_head   <= n_head;
            r_tail   <= n_tail;
            r_cnt    <= n_cnt;
            r_ovalid <= n_ovalid;
            if (i_cfg_we) r_sgn <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key    <= n_key;
        r_min    <= n_min;
        r_i      <= n_i;
        r_j      <= n_j;
        r_m      <= n_m;
        r_status <= n_status;
        r_data   <= n_data;
        r_found  <= n_found;
    end

    assign o_valid    = r_ovalid;
    assign o_status   = r_status;
    assign o_data_out = 32'(r_data);
    assign o_found    = r_found;
    assign o_count    = r_cnt;

`ifndef SYNTHESIS
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= FULL_CNT) else $error("count beyond capacity");
    a_ring: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        slot(r_head, r_cnt) == r_tail) else $error("head, tail and count disagree");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !accept) else $error("word taken while busy");
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_count) && $stable(o_status)))
        else $error("stalled result changed");
`endif
endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for the ring buffer deque core.
module tb_top;

    typedef struct packed {
        logic [2:0]  action;
        logic [31:0] value;
    } t_req_word;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] data;
        logic        found;
        logic [6:0]  count;
    } t_rsp_word;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_data = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [2:0]  i_action = '0;
    logic [31:0] i_elem_value = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [1:0]  o_status;
    logic [31:0] o_data_out;
    logic        o_found;
    logic [6:0]  o_count;

    // Shadow deque, front at index 0, plus the order register
    logic [31:0] deque_shadow[$];
    logic        order_signed = 1'b0;

    t_req_word   pending_words[$];
    t_rsp_word   expected_rsp[$];
    int          error_count = 0;
    logic        long_hold_req = 1'b0;
    logic        long_hold_done = 1'b0;
    logic        in_taken = 1'b0;

    ring_buffer_deque_core uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_action     (i_action),
        .i_elem_value (i_elem_value),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_status     (o_status),
        .o_data_out   (o_data_out),
        .o_found      (o_found),
        .o_count      (o_count)
    );

    always #10 i_clk = ~i_clk;

    function automatic logic elem_less(logic [31:0] a, logic [31:0] b);
        if (order_signed) begin
            return $signed(a) < $signed(b);
        end
        return a < b;
    endfunction

    // Apply one request to the shadow deque and return the result it yields.
    function automatic t_rsp_word apply_request(t_req_word w);
        t_rsp_word   r;
        logic [31:0] t;
        int          m;
        r = '0;
        case (w.action)
            rbd_pkg::ACT_PUSH_FRONT, rbd_pkg::ACT_PUSH_BACK: begin
                if (deque_shadow.size() >= 64) begin
                    r.status = rbd_pkg::ST_FULL;
                end else if (w.action == rbd_pkg::ACT_PUSH_FRONT) begin
                    deque_shadow.push_front(w.value);
                end else begin
                    deque_shadow.push_back(w.value);
                end
            end
            rbd_pkg::ACT_POP_FRONT, rbd_pkg::ACT_POP_BACK: begin
                if (deque_shadow.size() == 0) begin
                    r.status = rbd_pkg::ST_EMPTY;
                end else if (w.action == rbd_pkg::ACT_POP_FRONT) begin
                    r.data = deque_shadow.pop_front();
                end else begin
                    r.data = deque_shadow.pop_back();
                end
            end
            rbd_pkg::ACT_CONTAINS: begin
                foreach (deque_shadow[i]) begin
                    if (deque_shadow[i] == w.value) begin
                        r.found = 1'b1;
                    end
                end
            end
            rbd_pkg::ACT_SORT: begin
                for (int i = 0; i < deque_shadow.size(); i++) begin
                    m = i;
                    for (int j = i + 1; j < deque_shadow.size(); j++) begin
                        if (elem_less(deque_shadow[j], deque_shadow[m])) begin
                            m = j;
                        end
                    end
                    t = deque_shadow[m];
                    deque_shadow[m] = deque_shadow[i];
                    deque_shadow[i] = t;
                end
            end
            default: begin
            end
        endcase
        r.count = 7'(deque_shadow.size());
        return r;
    endfunction

    // Sample both channels at the rising edge: predict on input accept, check on output accept
    always @(posedge i_clk) begin
        t_rsp_word exp_w;
        in_taken <= i_rst_n && i_valid && !o_stall;
        if (i_rst_n && i_valid && !o_stall) begin
            expected_rsp.push_back(apply_request('{i_action, i_elem_value}));
        end
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_rsp.size() == 0) begin
                $error("result word with no expectation pending");
                error_count++;
            end else begin
                exp_w = expected_rsp.pop_front();
                if (o_status !== exp_w.status) begin
                    $error("status exp %0d got %0d", exp_w.status, o_status);
                    error_count++;
                end
                if (o_data_out !== exp_w.data) begin
                    $error("data_out exp %h got %h", exp_w.data, o_data_out);
                    error_count++;
                end
                if (o_found !== exp_w.found) begin
                    $error("found exp %0d got %0d", exp_w.found, o_found);
                    error_count++;
                end
                if (o_count !== exp_w.count) begin
                    $error("count exp %0d got %0d", exp_w.count, o_count);
                    error_count++;
                end
            end
        end
    end

    // Sender: hold a word until taken, otherwise advance in bursts separated by gaps
    int burst_left = 0;
    int gap_left = 0;
    always @(negedge i_clk) begin
        t_req_word w;
        if (i_rst_n && (!i_valid || in_taken)) begin
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                i_valid <= 1'b0;
            end else if (pending_words.size() != 0) begin
                w = pending_words.pop_front();
                i_valid <= 1'b1;
                i_action <= w.action;
                i_elem_value <= w.value;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 30);
                    gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 6);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Receiver: stall pattern changes mode every so often; a long hold-off on request
    int stall_mode = 0;
    int mode_left = 0;
    int hold_left = 0;
    always @(negedge i_clk) begin
        if (long_hold_req && !long_hold_done && hold_left == 0) begin
            hold_left <= 400;
            long_hold_done <= 1'b1;
            i_stall <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_stall <= (hold_left != 1);
        end else begin
            if (mode_left == 0) begin
                stall_mode <= $urandom_range(0, 2);
                mode_left <= $urandom_range(20, 120);
            end else begin
                mode_left <= mode_left - 1;
            end
            case (stall_mode)
                0: i_stall <= 1'b0;
                1: i_stall <= ($urandom_range(0, 9) < 3);
                default: i_stall <= ($urandom_range(0, 9) < 7);
            endcase
        end
    end

    // Values picked often from a small pool so contains hits and sort sees ties
    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 5))
            0: return 32'($urandom_range(0, 7));
            1: return 32'h8000_0000 + $urandom_range(0, 3);
            2: return 32'h7FFF_FFFF - $urandom_range(0, 3);
            3: return 32'hFFFF_FFFF - $urandom_range(0, 3);
            default: return $urandom;
        endcase
    endfunction

    task automatic queue_word(logic [2:0] act, logic [31:0] val);
        pending_words.push_back('{act, val});
    endtask

    // Push-heavy or pop-heavy chunks walk the deque between empty and full
    task automatic queue_random(int n);
        int          push_pct;
        int          r;
        logic [2:0]  act;
        for (int k = 0; k < n; k++) begin
            if (k % 48 == 0) begin
                push_pct = ($urandom_range(0, 1) == 0) ? 80 : 20;
            end
            r = $urandom_range(0, 99);
            if (r < 3) begin
                act = rbd_pkg::ACT_SORT;
            end else if (r < 10) begin
                act = rbd_pkg::ACT_CONTAINS;
            end else if (r < 12) begin
                act = 3'($urandom_range(6, 7));
            end else if (r < 12 + push_pct * 88 / 100) begin
                act = $urandom_range(0, 1) ? rbd_pkg::ACT_PUSH_BACK : rbd_pkg::ACT_PUSH_FRONT;
            end else begin
                act = $urandom_range(0, 1) ? rbd_pkg::ACT_POP_BACK : rbd_pkg::ACT_POP_FRONT;
            end
            queue_word(act, pick_value());
        end
    endtask

    task automatic drain_all();
        while (pending_words.size() != 0 || i_valid || expected_rsp.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_order(logic val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_data <= val;
        order_signed = val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        write_order(1'b0);
        // Directed: empty rejects, extremes, both orders of sort, unused codes
        queue_word(rbd_pkg::ACT_POP_FRONT, 32'h0);
        queue_word(rbd_pkg::ACT_POP_BACK, 32'h0);
        queue_word(rbd_pkg::ACT_SORT, 32'h0);
        queue_word(rbd_pkg::ACT_CONTAINS, 32'h0);
        queue_word(rbd_pkg::ACT_PUSH_BACK, 32'hFFFF_FFFF);
        queue_word(rbd_pkg::ACT_SORT, 32'h0);
        queue_word(rbd_pkg::ACT_PUSH_FRONT, 32'h8000_0000);
        queue_word(rbd_pkg::ACT_PUSH_BACK, 32'h0);
        queue_word(rbd_pkg::ACT_PUSH_FRONT, 32'h7FFF_FFFF);
        queue_word(rbd_pkg::ACT_PUSH_BACK, 32'h0000_0001);
        queue_word(rbd_pkg::ACT_CONTAINS, 32'h8000_0000);
        queue_word(rbd_pkg::ACT_CONTAINS, 32'h1234_5678);
        queue_word(3'd6, 32'hFFFF_FFFF);
        queue_word(3'd7, 32'h0);
        queue_word(rbd_pkg::ACT_SORT, 32'h0);
        queue_word(rbd_pkg::ACT_POP_FRONT, 32'h0);
        queue_word(rbd_pkg::ACT_POP_BACK, 32'h0);
        drain_all();

        write_order(1'b1);
        queue_word(rbd_pkg::ACT_PUSH_BACK, 32'h8000_0000);
        queue_word(rbd_pkg::ACT_PUSH_BACK, 32'hFFFF_FFFF);
        queue_word(rbd_pkg::ACT_SORT, 32'h0);
        queue_word(rbd_pkg::ACT_POP_FRONT, 32'h0);
        queue_word(rbd_pkg::ACT_POP_FRONT, 32'h0);
        queue_word(rbd_pkg::ACT_POP_FRONT, 32'h0);
        queue_word(rbd_pkg::ACT_POP_BACK, 32'h0);
        queue_word(rbd_pkg::ACT_POP_FRONT, 32'h0);
        drain_all();

        // Random phases across both orders; pushes past capacity and a long hold-off
        write_order(1'b0);
        queue_random(500);
        drain_all();
        write_order(1'b1);
        for (int k = 0; k < 70; k++) begin
            queue_word(rbd_pkg::ACT_PUSH_BACK, pick_value());
        end
        long_hold_req = 1'b1;
        queue_random(500);
        drain_all();
        write_order(1'b0);
        queue_random(550);

        drain_all();
        repeat (3000) @(posedge i_clk);
        if (error_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #100_000_000;
        $display("Test completed with failures");
        $finish;
    end
endmodule
